// ===== hw/rtl/mte_pkg.sv =====
// shared types, symbol codes and the character lookup for the morse encoder
// no dependencies
package mte_pkg;

  typedef enum logic [1:0] {
    SYM_DOT  = 2'd0,
    SYM_DASH = 2'd1,
    SYM_GAP  = 2'd2,
    SYM_WORD = 2'd3
  } sym_t;

  localparam int unsigned MaxSyms = 7;
  localparam int unsigned MaxElems = 6;
  localparam int unsigned IdxW = $clog2(MaxSyms);
  localparam int unsigned ChrW = 8;

  typedef struct packed {
    logic [IdxW-1:0]        last_idx;
    logic [MaxSyms-1:0][1:0] syms;
  } job_t;

  typedef struct packed {
    logic known;
    job_t job;
  } class_t;

  // queue push side and pop side
  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  // first element in pat[5], 1 means dash
  function automatic class_t mte_classify(input logic [ChrW-1:0] ch);
    logic [ChrW-1:0] up;
    logic            known;
    logic [IdxW-1:0] len;
    logic [MaxElems-1:0] pat;
    class_t          res;
    up = ch;
    if (ch >= "a" && ch <= "z") begin
      up = ch & 8'hDF;
    end
    known = 1'b1;
    len = 3'd0;
    pat = 6'b000000;
    unique case (up)
      "A": begin len = 3'd2; pat = 6'b010000; end
      "B": begin len = 3'd4; pat = 6'b100000; end
      "C": begin len = 3'd4; pat = 6'b101000; end
      "D": begin len = 3'd3; pat = 6'b100000; end
      "E": begin len = 3'd1; pat = 6'b000000; end
      "F": begin len = 3'd4; pat = 6'b001000; end
      "G": begin len = 3'd3; pat = 6'b110000; end
      "H": begin len = 3'd4; pat = 6'b000000; end
      "I": begin len = 3'd2; pat = 6'b000000; end
      "J": begin len = 3'd4; pat = 6'b011100; end
      "K": begin len = 3'd3; pat = 6'b101000; end
      "L": begin len = 3'd4; pat = 6'b010000; end
      "M": begin len = 3'd2; pat = 6'b110000; end
      "N": begin len = 3'd2; pat = 6'b100000; end
      "O": begin len = 3'd3; pat = 6'b111000; end
      "P": begin len = 3'd4; pat = 6'b011000; end
      "Q": begin len = 3'd4; pat = 6'b110100; end
      "R": begin len = 3'd3; pat = 6'b010000; end
      "S": begin len = 3'd3; pat = 6'b000000; end
      "T": begin len = 3'd1; pat = 6'b100000; end
      "U": begin len = 3'd3; pat = 6'b001000; end
      "V": begin len = 3'd4; pat = 6'b000100; end
      "W": begin len = 3'd3; pat = 6'b011000; end
      "X": begin len = 3'd4; pat = 6'b100100; end
      "Y": begin len = 3'd4; pat = 6'b101100; end
      "Z": begin len = 3'd4; pat = 6'b110000; end
      "0": begin len = 3'd5; pat = 6'b111110; end
      "1": begin len = 3'd5; pat = 6'b011110; end
      "2": begin len = 3'd5; pat = 6'b001110; end
      "3": begin len = 3'd5; pat = 6'b000110; end
      "4": begin len = 3'd5; pat = 6'b000010; end
      "5": begin len = 3'd5; pat = 6'b000000; end
      "6": begin len = 3'd5; pat = 6'b100000; end
      "7": begin len = 3'd5; pat = 6'b110000; end
      "8": begin len = 3'd5; pat = 6'b111000; end
      "9": begin len = 3'd5; pat = 6'b111100; end
      ".": begin len = 3'd6; pat = 6'b010101; end
      ",": begin len = 3'd6; pat = 6'b110011; end
      ":": begin len = 3'd6; pat = 6'b111000; end
      "?": begin len = 3'd6; pat = 6'b001100; end
      8'h27: begin len = 3'd6; pat = 6'b011110; end
      "-": begin len = 3'd6; pat = 6'b100001; end
      "/": begin len = 3'd5; pat = 6'b100100; end
      "(": begin len = 3'd5; pat = 6'b101100; end
      ")": begin len = 3'd6; pat = 6'b101101; end
      8'h22: begin len = 3'd6; pat = 6'b010010; end
      "&": begin len = 3'd5; pat = 6'b010000; end
      default: known = 1'b0;
    endcase
    res.known = known;
    for (int i = 0; i < MaxSyms; i++) begin
      res.job.syms[i] = SYM_GAP;
    end
    for (int i = 0; i < MaxElems; i++) begin
      if (IdxW'(i) < len) begin
        res.job.syms[i] = pat[MaxElems-1-i] ? SYM_DASH : SYM_DOT;
      end
    end
    res.job.last_idx = len;
    // space: separator then two gaps
    if (ch == " ") begin
      res.known = 1'b1;
      res.job.syms[0] = SYM_WORD;
      res.job.last_idx = 3'd2;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/mte_front.sv =====
// front stage: accepts characters, looks up their code and drops unknown ones
// depends on mte_pkg
module mte_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [mte_pkg::ChrW-1:0] in_character,
  input  logic                     q_full,
  output mte_pkg::q_push_t         q_push
);
  import mte_pkg::*;

  logic   fr_valid_r, fr_valid_nxt;
  job_t   fr_job_r;
  class_t cls;
  logic   in_fire;

  assign cls      = mte_classify(in_character);
  assign in_stall = fr_valid_r && q_full;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    fr_valid_nxt = fr_valid_r && q_full;
    if (in_fire) begin
      fr_valid_nxt = cls.known;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fr_job_r <= cls.job;
    end
  end

  assign q_push.valid = fr_valid_r;
  assign q_push.job   = fr_job_r;

endmodule

// ===== hw/rtl/mte_queue.sv =====
// two-entry queue of looked-up character codes between front and back
// depends on mte_pkg
module mte_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mte_pkg::q_push_t q_push,
  output logic             q_full,
  output mte_pkg::q_head_t q_head,
  input  logic             q_pop
);
  import mte_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign q_full  = count_r == 2'd2;
  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && count_r != 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.job;
    end
  end

  assign q_head.valid = count_r != 2'd0;
  assign q_head.job   = mem_r[rd_ptr_r];

endmodule

// ===== hw/rtl/mte_back.sv =====
// back stage: plays out the symbols of one character, one per cycle unless out_stall holds it, on the result channel
// depends on mte_pkg
module mte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mte_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_symbol,
  output logic             out_last_of_run
);
  import mte_pkg::*;

  logic            busy_r, busy_nxt;
  job_t            job_r, job_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_fire, at_last;

  assign out_fire = busy_r && !out_stall;
  assign at_last  = idx_r == job_r.last_idx;
  assign q_pop    = q_head.valid && (!busy_r || (out_fire && at_last));

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      job_nxt  = q_head.job;
      idx_nxt  = '0;
    end else if (out_fire && at_last) begin
      busy_nxt = 1'b0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign out_valid       = busy_r;
  assign out_symbol      = job_r.syms[idx_r];
  assign out_last_of_run = at_last;

endmodule

// ===== hw/rtl/morse_text_encoder.sv =====
// International Morse encoder: one ASCII character in per word, one symbol out per word
// (symbols 0 dot, 1 dash, 2 gap, 3 word separator; last_of_run marks the closing gap).
// Letters match in either case; digits and . , : ? ' - / ( ) " & are covered, a space
// gives separator, gap, gap, and any other character is taken and produces nothing.
// The result side sends one symbol per cycle while out_stall is low; a character's run is
// its code followed by a gap (separator, gap, gap for a space), stepped through by the back
// stage's symbol counter. The first symbol appears once the character has passed the front
// register, the two-entry queue and the back stage's registers, and the front keeps
// taking characters while the back is busy until the queue fills. No clearing pass
// after reset.
// depends on mte_pkg, mte_front, mte_queue, mte_back
module morse_text_encoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [mte_pkg::ChrW-1:0] in_character,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_symbol,
  output logic                     out_last_of_run
);
  import mte_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  mte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  mte_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  mte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== hw/rtl/mte_checker.sv =====
// port-level checks on the morse encoder, bound to the top level
// depends on mte_pkg, morse_text_encoder
module mte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_symbol,
  input logic       out_last_of_run
);
  import mte_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last_of_run))
    else $error("stalled result word changed");

  // every run closes on a gap
  a_last_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_symbol == SYM_GAP)
    else $error("run closed on a non-gap symbol");

  // separator is never the end of a run
  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol == SYM_WORD |-> !out_last_of_run)
    else $error("separator flagged as last");

  // separator is followed at once by a gap
  a_word_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_symbol == SYM_WORD |=>
      out_valid && out_symbol == SYM_GAP && !out_last_of_run)
    else $error("separator not followed by first gap");

  // a gap that does not close a run follows a separator or holds while stalled
  a_inner_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol == SYM_GAP && !out_last_of_run |->
      $past(out_valid) && ($past(out_symbol) == SYM_WORD ||
        ($past(out_stall) && $past(out_symbol) == SYM_GAP && !$past(out_last_of_run))))
    else $error("inner gap without separator");

endmodule

bind morse_text_encoder mte_checker u_mte_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_symbol      (out_symbol),
  .out_last_of_run (out_last_of_run)
);

// ===== bench/morse_text_encoder_tb.sv =====
// testbench for morse_text_encoder: a directed table of characters, then random text,
// every symbol word checked against an in-bench morse lookup with random stalls both sides
// depends on mte_pkg and morse_text_encoder
`timescale 1ns / 1ps

module morse_text_encoder_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 21;
  localparam int TEXT_ITEMS = 95;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    mte_pkg::sym_t symbol;
    logic          last_of_run;
  } symbol_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_character = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_symbol;
  logic       out_last_of_run;

  logic         calm = 1'b0;
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  symbol_word_t expected_symbols[$];

  string letter_codes[26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  string digit_codes[10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  // "*" means take the run from the lookup
  logic [7:0] dir_char[25] = '{
    8'h00, 8'hFF, 8'h80, 8'h7F, " ", "E", "T", "A", "a", "Z", "z", "0", "9",
    ".", ",", ":", "?", 8'h27, "-", "/", "(", ")", 8'h22, "&", "@"
  };

  string dir_run[25] = '{
    "", "", "", "*", "/  ", ". ", "- ", "*", "*", "*", "*", "----- ", "*",
    ".-.-.- ", "*", "*", "*", "*", "*", "*", "*", "*", "*", ".-... ", ""
  };

  string text_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,:?'-/()\"&";

  morse_text_encoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_character    (in_character),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run of one character: '.' dot, '-' dash, ' ' gap, '/' word separator
  function automatic string morse_run(input logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    if (ch >= "a" && ch <= "z") begin
      up = ch - 8'd32;
    end
    if (ch == " ") begin
      return "/  ";
    end
    if (up >= "A" && up <= "Z") begin
      return {letter_codes[up - "A"], " "};
    end
    if (up >= "0" && up <= "9") begin
      return {digit_codes[up - "0"], " "};
    end
    case (up)
      ".":   return ".-.-.- ";
      ",":   return "--..-- ";
      ":":   return "---... ";
      "?":   return "..--.. ";
      8'h27: return ".----. ";
      "-":   return "-....- ";
      "/":   return "-..-. ";
      "(":   return "-.--. ";
      ")":   return "-.--.- ";
      8'h22: return ".-..-. ";
      "&":   return ".-... ";
      default: return "";
    endcase
  endfunction

  task automatic queue_run(input string run);
    symbol_word_t w;
    for (int i = 0; i < run.len(); i++) begin
      case (run[i])
        "-":     w.symbol = mte_pkg::SYM_DASH;
        " ":     w.symbol = mte_pkg::SYM_GAP;
        "/":     w.symbol = mte_pkg::SYM_WORD;
        default: w.symbol = mte_pkg::SYM_DOT;
      endcase
      w.last_of_run = (i == run.len() - 1);
      expected_symbols.push_back(w);
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input string run);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= ch;
    do @(posedge clk); while (in_stall);
    queue_run(run);
  endtask

  always @(posedge clk) begin : symbol_check
    symbol_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected word, symbol %0d last %0b", $time, out_symbol,
                 out_last_of_run);
        mismatch_count++;
      end else begin
        want = expected_symbols.pop_front();
        if (out_symbol !== want.symbol) begin
          $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, out_symbol);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, want.last_of_run,
                   out_last_of_run);
          mismatch_count++;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] ch;
    string      run;
    int         pick;
    int         sent;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      run = (dir_run[i] == "*") ? morse_run(dir_char[i]) : dir_run[i];
      send_char(dir_char[i], run);
    end

    sent = 0;
    while (sent < TEXT_ITEMS) begin
      calm <= (sent >= 40 && sent < 70);
      pick = $urandom_range(99);
      if (pick < 70) begin
        ch = text_chars[$urandom_range(text_chars.len() - 1)];
      end else if (pick < 82) begin
        ch = " ";
      end else begin
        ch = 8'($urandom_range(255));
      end
      run = morse_run(ch);
      send_char(ch, run);
      sent++;
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    while (expected_symbols.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_symbols.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
